@@ design/bbtr_pkg.sv @@
// Shared types and constants for the bounding-box triangle rasterizer.
// Used by bbtr_ctrl, bbtr_dpath and bounding_box_triangle_raster.
package bbtr_pkg;

  localparam int TILE_SIZE_DEF = 64;
  localparam int NUM_VERT      = 3;
  localparam int COORD_W       = 6;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int EDGE_W        = 16;
  localparam int COLOR_W       = 32;
  localparam int ROWS_W        = 64;
  localparam int S_DATA_W      = 72;
  localparam int M_DATA_W      = 104;

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [ROWS_W-1:0]         rows_t;

  // Edge being set up: a->b, b->c, c->a
  typedef enum logic [1:0] {
    EDGE_AB,
    EDGE_BC,
    EDGE_CA
  } edge_id_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     box;
    logic     base;
    edge_id_t edge_sel;
    logic     init;
    logic     emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_col;
  } status_t;

endpackage

@@ design/bbtr_ctrl.sv @@
// Sequencer for the triangle rasterizer: setup steps, then one column per cycle while the output is not stalled.
// Depends on bbtr_pkg (cmd_t, status_t, edge_id_t).
module bbtr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  bbtr_pkg::status_t status,
  output bbtr_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    BOX,
    BASE,
    INIT,
    WALK
  } state_t;

  state_t             state;
  bbtr_pkg::edge_id_t edge_cnt;
  bbtr_pkg::edge_id_t edge_cnt_next;

  assign s_tready = (state == IDLE);

  // next edge to set up
  always_comb begin
    case (edge_cnt)
      bbtr_pkg::EDGE_AB: edge_cnt_next = bbtr_pkg::EDGE_BC;
      bbtr_pkg::EDGE_BC: edge_cnt_next = bbtr_pkg::EDGE_CA;
      default:           edge_cnt_next = bbtr_pkg::EDGE_AB;
    endcase
  end

  // command decode
  always_comb begin
    cmd = '0;
    case (state)
      IDLE: cmd.load = s_tvalid;
      BOX:  cmd.box  = 1'b1;
      BASE: begin
        cmd.base     = 1'b1;
        cmd.edge_sel = edge_cnt;
      end
      INIT: cmd.init = 1'b1;
      WALK: cmd.emit = !m_tvalid || m_tready;
      default: cmd = '0;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      edge_cnt <= bbtr_pkg::EDGE_AB;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) state <= BOX;
        end
        BOX: begin
          state    <= BASE;
          edge_cnt <= bbtr_pkg::EDGE_AB;
        end
        BASE: begin
          if (edge_cnt == bbtr_pkg::EDGE_CA) state <= INIT;
          else edge_cnt <= edge_cnt_next;
        end
        INIT: state <= WALK;
        WALK: begin
          if (cmd.emit && status.last_col) state <= IDLE;
        end
        default: state <= IDLE;
      endcase

      if (cmd.emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

@@ design/bbtr_dpath.sv @@
// Datapath: vertex latch, bounding box, edge setup, row lanes of edge values,
// and the output register. Depends on bbtr_pkg.
module bbtr_dpath #(
  parameter int TILE_SIZE = bbtr_pkg::TILE_SIZE_DEF
) (
  input  logic                            clk,
  input  bbtr_pkg::cmd_t                  cmd,
  output bbtr_pkg::status_t               status,
  input  logic [bbtr_pkg::S_DATA_W-1:0]   s_tdata,
  output logic [bbtr_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                            m_tlast
);

  localparam int NV = bbtr_pkg::NUM_VERT;
  localparam int CW = bbtr_pkg::COORD_W;
  localparam bbtr_pkg::coord_t MAX_COORD = bbtr_pkg::coord_t'(TILE_SIZE - 1);

  bbtr_pkg::coord_t vx [NV];
  bbtr_pkg::coord_t vy [NV];
  bbtr_pkg::color_t color;
  bbtr_pkg::coord_t x0, y0, x1, y1;
  bbtr_pkg::diff_t  dx [NV];
  bbtr_pkg::diff_t  dy [NV];
  bbtr_pkg::edge_t  base [NV];
  bbtr_pkg::edge_t  lane [NV][TILE_SIZE];
  bbtr_pkg::coord_t col;

  bbtr_pkg::coord_t out_col;
  bbtr_pkg::rows_t  out_rows;
  bbtr_pkg::color_t out_color;
  logic             out_last;

  bbtr_pkg::coord_t in_coord [2*NV];
  bbtr_pkg::coord_t sel_ux, sel_uy;
  bbtr_pkg::diff_t  sel_dx, sel_dy, off_x;
  logic signed [2*bbtr_pkg::DIFF_W-1:0] prod_x, prod_y;
  logic [TILE_SIZE-1:0] row_hit;

  // unpack and saturate input coordinates
  always_comb begin
    for (int i = 0; i < 2*NV; i++) begin
      in_coord[i] = s_tdata[i*CW +: CW];
      if (in_coord[i] > MAX_COORD) in_coord[i] = MAX_COORD;
    end
  end

  // edge select for base setup
  always_comb begin
    case (cmd.edge_sel)
      bbtr_pkg::EDGE_AB: begin
        sel_ux = vx[0]; sel_uy = vy[0]; sel_dx = dx[0]; sel_dy = dy[0];
      end
      bbtr_pkg::EDGE_BC: begin
        sel_ux = vx[1]; sel_uy = vy[1]; sel_dx = dx[1]; sel_dy = dy[1];
      end
      default: begin
        sel_ux = vx[2]; sel_uy = vy[2]; sel_dx = dx[2]; sel_dy = dy[2];
      end
    endcase
    off_x  = $signed({1'b0, x0}) - $signed({1'b0, sel_ux});
    prod_x = sel_dy * off_x;
    prod_y = sel_dx * $signed({1'b0, sel_uy});
  end

  // row coverage: inside box rows and every edge value >= 0, or every edge value <= 0
  always_comb begin
    for (int y = 0; y < TILE_SIZE; y++) begin
      row_hit[y] = (bbtr_pkg::coord_t'(y) >= y0) && (bbtr_pkg::coord_t'(y) <= y1) &&
                   (((lane[0][y] >= 0) && (lane[1][y] >= 0) && (lane[2][y] >= 0)) ||
                    ((lane[0][y] <= 0) && (lane[1][y] <= 0) && (lane[2][y] <= 0)));
    end
  end

  assign status.last_col = (col == x1);

  // triangle latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NV; i++) begin
        vx[i] <= in_coord[2*i];
        vy[i] <= in_coord[2*i+1];
      end
      color <= s_tdata[2*NV*CW +: bbtr_pkg::COLOR_W];
    end
  end

  // bounding box and edge deltas
  always_ff @(posedge clk) begin
    if (cmd.box) begin
      x0 <= (vx[0] < vx[1]) ? ((vx[0] < vx[2]) ? vx[0] : vx[2])
                            : ((vx[1] < vx[2]) ? vx[1] : vx[2]);
      y0 <= (vy[0] < vy[1]) ? ((vy[0] < vy[2]) ? vy[0] : vy[2])
                            : ((vy[1] < vy[2]) ? vy[1] : vy[2]);
      x1 <= (vx[0] > vx[1]) ? ((vx[0] > vx[2]) ? vx[0] : vx[2])
                            : ((vx[1] > vx[2]) ? vx[1] : vx[2]);
      y1 <= (vy[0] > vy[1]) ? ((vy[0] > vy[2]) ? vy[0] : vy[2])
                            : ((vy[1] > vy[2]) ? vy[1] : vy[2]);
      for (int k = 0; k < NV; k++) begin
        dx[k] <= $signed({1'b0, vx[(k + 1) % NV]}) - $signed({1'b0, vx[k]});
        dy[k] <= $signed({1'b0, vy[(k + 1) % NV]}) - $signed({1'b0, vy[k]});
      end
    end
  end

  // edge value at (x0, 0), one edge per cycle
  always_ff @(posedge clk) begin
    if (cmd.base) begin
      case (cmd.edge_sel)
        bbtr_pkg::EDGE_AB: base[0] <= bbtr_pkg::edge_t'(prod_x) + bbtr_pkg::edge_t'(prod_y);
        bbtr_pkg::EDGE_BC: base[1] <= bbtr_pkg::edge_t'(prod_x) + bbtr_pkg::edge_t'(prod_y);
        default:           base[2] <= bbtr_pkg::edge_t'(prod_x) + bbtr_pkg::edge_t'(prod_y);
      endcase
    end
  end

  // row lanes: load column x0, then step by dy per column
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int k = 0; k < NV; k++) begin
        for (int y = 0; y < TILE_SIZE; y++) begin
          lane[k][y] <= base[k] - bbtr_pkg::edge_t'(dx[k]) * bbtr_pkg::edge_t'(y);
        end
      end
    end else if (cmd.emit) begin
      for (int k = 0; k < NV; k++) begin
        for (int y = 0; y < TILE_SIZE; y++) begin
          lane[k][y] <= lane[k][y] + bbtr_pkg::edge_t'(dy[k]);
        end
      end
    end
  end

  // column counter
  always_ff @(posedge clk) begin
    if (cmd.init) col <= x0;
    else if (cmd.emit) col <= col + 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_col   <= col;
      out_rows  <= bbtr_pkg::rows_t'(row_hit);
      out_color <= color;
      out_last  <= status.last_col;
    end
  end

  assign m_tdata = {2'b00, out_color, out_rows, out_col};
  assign m_tlast = out_last;

endmodule

@@ design/bounding_box_triangle_raster.sv @@
// Bounding-box triangle rasterizer, one tile of TILE_SIZE x TILE_SIZE pixels.
// The input is taken in the idle state; setup then runs the box step, the setup of
// each edge on one shared multiplier pair and the lane load, and the row lanes then
// test one column per cycle while the output is not stalled. A new triangle is
// accepted only after the last column of the previous one has been emitted.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module bounding_box_triangle_raster #(
  parameter int TILE_SIZE = bbtr_pkg::TILE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [5:0] vertex_a_x, [11:6] vertex_a_y, [17:12] vertex_b_x, [23:18] vertex_b_y,
  // [29:24] vertex_c_x, [35:30] vertex_c_y, [67:36] fill_color, [71:68] zero
  input  logic [bbtr_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [5:0] column, [69:6] covered_rows, [101:70] pixel_color, [103:102] zero
  output logic [bbtr_pkg::M_DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);

  bbtr_pkg::cmd_t    cmd;
  bbtr_pkg::status_t status;

  bbtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bbtr_dpath #(
    .TILE_SIZE (TILE_SIZE)
  ) u_dpath (
    .clk     (clk),
    .cmd     (cmd),
    .status  (status),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule
